// ===== design/terrain_height_sampler_assert.svh =====
// Assertion macros for the terrain height sampler.
`ifndef TERRAIN_HEIGHT_SAMPLER_ASSERT_SVH
`define TERRAIN_HEIGHT_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define THS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define THS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define THS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define THS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ths_pkg.sv =====
// Shared types and constants of the terrain height sampler.
package ths_pkg;
	localparam int unsigned MAX_DIM = 256;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned POS_W = 24;
	localparam int unsigned RECIP_W = 24;
	localparam int unsigned DIM_W = 9;
	localparam int unsigned HGT_W = 16;
	localparam int unsigned FRAC_BITS = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH = 2'd0,
		REG_MAP_LENGTH = 2'd1,
		REG_RECIP_X = 2'd2,
		REG_RECIP_Z = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	// Classified item handed from front to back.
	typedef struct packed {
		logic query;
		logic outside;
		logic reverse;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fz;
		logic [ADDR_W-1:0] a_bl;
		logic [ADDR_W-1:0] a_br;
		logic [ADDR_W-1:0] a_tl;
		logic [ADDR_W-1:0] a_tr;
	} ths_item_t;
endpackage

// ===== design/ths_front.sv =====
// Front: scales the position, classifies the query, computes corner addresses.
module ths_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              kind,
	input  logic signed [ths_pkg::POS_W-1:0]  pos_x,
	input  logic signed [ths_pkg::POS_W-1:0]  pos_z,
	input  logic                              reverse_quad,
	input  logic [ths_pkg::DIM_W-1:0]         eff_w,
	input  logic [ths_pkg::DIM_W-1:0]         eff_l,
	input  logic [ths_pkg::RECIP_W-1:0]       recip_x,
	input  logic [ths_pkg::RECIP_W-1:0]       recip_z,
	output logic                              item_valid,
	output ths_pkg::ths_item_t                item
);
	import ths_pkg::*;

	localparam int unsigned PROD_W = POS_W + RECIP_W + 1;
	localparam int unsigned GRID_W = PROD_W - 16;

	// stage 1: products
	logic signed [PROD_W-1:0] px_s1, pz_s1;
	logic v_s1, q_s1, rev_s1;
	// stage 2: cell and fraction
	logic v_s2, q_s2, rev_s2, out_s2;
	logic [DIM_W-1:0] cx_s2, cz_s2, x1_s2, z1_s2;
	logic [FRAC_BITS-1:0] fx_s2, fz_s2;
	// stage 3: row bases (one multiply each)
	logic v_s3;
	logic [ADDR_W+DIM_W-1:0] rb0_s3, rb1_s3;

	logic [GRID_W-1:0] gx, gz;
	logic [GRID_W-FRAC_BITS-1:0] cxw, czw;
	logic out_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= PROD_W'(pos_x) * $signed({1'b0, recip_x});
		pz_s1 <= PROD_W'(pos_z) * $signed({1'b0, recip_z});
		q_s1 <= (kind == KIND_QUERY);
		rev_s1 <= reverse_quad;
	end

	always_comb begin
		gx = GRID_W'(px_s1 >>> 16);
		gz = GRID_W'(pz_s1 >>> 16);
		cxw = gx[GRID_W-1:FRAC_BITS];
		czw = gz[GRID_W-1:FRAC_BITS];
		out_c = px_s1[PROD_W-1] || pz_s1[PROD_W-1]
			|| (cxw >= (GRID_W-FRAC_BITS)'(eff_w))
			|| (czw >= (GRID_W-FRAC_BITS)'(eff_l));
	end

	always_ff @(posedge clk) begin
		q_s2 <= q_s1;
		rev_s2 <= rev_s1;
		out_s2 <= out_c;
		cx_s2 <= DIM_W'(cxw);
		cz_s2 <= DIM_W'(czw);
		x1_s2 <= ((cxw + 1'b1) < (GRID_W-FRAC_BITS)'(eff_w)) ? DIM_W'(cxw + 1'b1)
			: DIM_W'(cxw);
		z1_s2 <= ((czw + 1'b1) < (GRID_W-FRAC_BITS)'(eff_l)) ? DIM_W'(czw + 1'b1)
			: DIM_W'(czw);
		fx_s2 <= gx[FRAC_BITS-1:0];
		fz_s2 <= gz[FRAC_BITS-1:0];
	end

	logic [DIM_W-1:0] cx_s3, x1_s3;
	logic q_s3, rev_s3, out_s3;
	logic [FRAC_BITS-1:0] fx_s3, fz_s3;

	always_ff @(posedge clk) begin
		rb0_s3 <= (ADDR_W+DIM_W)'(cz_s2 * eff_w);
		rb1_s3 <= (ADDR_W+DIM_W)'(z1_s2 * eff_w);
		cx_s3 <= cx_s2;
		x1_s3 <= x1_s2;
		q_s3 <= q_s2;
		rev_s3 <= rev_s2;
		out_s3 <= out_s2;
		fx_s3 <= fx_s2;
		fz_s3 <= fz_s2;
	end

	assign item_valid = v_s3;
	always_comb begin
		item.query = q_s3;
		item.outside = out_s3;
		item.reverse = rev_s3;
		item.fx = fx_s3;
		item.fz = fz_s3;
		item.a_bl = ADDR_W'(rb0_s3 + cx_s3);
		item.a_br = ADDR_W'(rb0_s3 + x1_s3);
		item.a_tl = ADDR_W'(rb1_s3 + cx_s3);
		item.a_tr = ADDR_W'(rb1_s3 + x1_s3);
	end
endmodule

// ===== design/ths_queue.sv =====
// Short FIFO between front and back.
module ths_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ths_pkg::ths_item_t push_item,
	input  logic               pop,
	output logic               not_empty,
	output ths_pkg::ths_item_t head
);
	import ths_pkg::*;

	ths_item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign not_empty = (cnt_q != 3'd0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

	`include "terrain_height_sampler_assert.svh"
	`THS_ASSERT_IMP(a_no_overflow, clk, arst_n, cnt_q == 3'd4, !push || pop)
	`THS_ASSERT_IMP(a_no_underflow, clk, arst_n, cnt_q == 3'd0, !pop)
	`THS_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 3'd4)
endmodule

// ===== design/ths_back.sv =====
// Back: heightmap memory, corner reads, triangle split and bilinear blend.
module ths_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [ths_pkg::ADDR_W-1:0] wr_addr,
	input  logic [7:0]                 wr_data,
	input  logic                       item_valid,
	input  ths_pkg::ths_item_t         item,
	output logic                       pop,
	output logic                       done,
	output logic [ths_pkg::HGT_W-1:0]  height,
	output logic                       outside
);
	import ths_pkg::*;

	localparam int unsigned ONE = 1 << FRAC_BITS;

	// one bank per corner, all written alike
	logic [7:0] bank_bl [MAX_DIM*MAX_DIM];
	logic [7:0] bank_br [MAX_DIM*MAX_DIM];
	logic [7:0] bank_tl [MAX_DIM*MAX_DIM];
	logic [7:0] bank_tr [MAX_DIM*MAX_DIM];

	logic v_s1, q_s1, out_s1, rev_s1;
	logic [FRAC_BITS-1:0] fx_s1, fz_s1;
	logic [7:0] bl_s1, br_s1, tl_s1, tr_s1;

	assign pop = item_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bank_bl[wr_addr] <= wr_data;
			bank_br[wr_addr] <= wr_data;
			bank_tl[wr_addr] <= wr_data;
			bank_tr[wr_addr] <= wr_data;
		end
		bl_s1 <= bank_bl[item.a_bl];
		br_s1 <= bank_br[item.a_br];
		tl_s1 <= bank_tl[item.a_tl];
		tr_s1 <= bank_tr[item.a_tr];
		q_s1 <= item.query;
		out_s1 <= item.outside;
		rev_s1 <= item.reverse;
		fx_s1 <= item.fx;
		fz_s1 <= item.fz;
	end

	// corner adjust, then row blend
	logic signed [10:0] bl, br, tl, tr;
	logic signed [FRAC_BITS+1:0] fxs, fzs, onefx;
	logic signed [FRAC_BITS+12:0] top_c, bot_c;

	always_comb begin
		bl = 11'(bl_s1);
		br = 11'(br_s1);
		tl = 11'(tl_s1);
		tr = 11'(tr_s1);
		fxs = (FRAC_BITS+2)'(fx_s1);
		fzs = (FRAC_BITS+2)'(fz_s1);
		onefx = (FRAC_BITS+2)'(ONE) - fxs;
		if (rev_s1) begin
			if (fzs >= fxs) br = bl + tr - tl;
			else tl = tr + bl - br;
		end else begin
			if (fzs < onefx) tr = tl + br - bl;
			else bl = tl + br - tr;
		end
		top_c = (FRAC_BITS+13)'(tl * onefx) + (FRAC_BITS+13)'(tr * fxs);
		bot_c = (FRAC_BITS+13)'(bl * onefx) + (FRAC_BITS+13)'(br * fxs);
	end

	logic v_s2, q_s2, out_s2;
	logic signed [FRAC_BITS+12:0] top_s2, bot_s2;
	logic [FRAC_BITS-1:0] fz_s2;

	always_ff @(posedge clk) begin
		top_s2 <= top_c;
		bot_s2 <= bot_c;
		fz_s2 <= fz_s1;
		q_s2 <= q_s1;
		out_s2 <= out_s1;
	end

	localparam int unsigned HW = 2*FRAC_BITS + 15;
	logic signed [HW-1:0] h_c;
	logic signed [FRAC_BITS+1:0] fz2, onefz;
	logic [HW-1:0] rnd;
	logic [HGT_W-1:0] res;

	always_comb begin
		fz2 = (FRAC_BITS+2)'(fz_s2);
		onefz = (FRAC_BITS+2)'(ONE) - fz2;
		h_c = HW'(bot_s2 * onefz) + HW'(top_s2 * fz2);
		rnd = (HW'(h_c) + HW'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
		if (h_c <= 0) res = '0;
		else if (rnd > HW'(16'hFFFF)) res = '1;
		else res = HGT_W'(rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			done <= v_s2 && q_s2;
		end
	end

	always_ff @(posedge clk) begin
		outside <= out_s2;
		height <= out_s2 ? '0 : res;
	end

	`include "terrain_height_sampler_assert.svh"
	`THS_ASSERT_NXT(a_pipe, clk, arst_n, item_valid, v_s1)
	`THS_ASSERT_NXT(a_done_src, clk, arst_n, !v_s2, !done)
	`THS_ASSERT_IMP(a_out_zero, clk, arst_n, done && outside, height == '0)
endmodule

// ===== design/terrain_height_sampler.sv =====
// Top level of the terrain height sampler.
// channel | signals                                            | handshake
// input   | kind load_index load_value pos_x pos_z reverse_quad | start && !busy
// result  | height outside                                     | done, one cycle
// config  | cfg_we cfg_index cfg_data                          | cfg_we
// One item per cycle. A query result passes the three front stages
// (scale multiply, cell, row base multiply), the queue, the registered
// memory read, two blend stages and the output register.
// Loads pass through the load delay registers before writing the heightmap; busy stays low.
// Reset clears valid flags, presets config; data and heightmap are undefined.
// The receiver cannot stall; results are never held back.
module terrain_height_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                kind,
	input  logic [ths_pkg::ADDR_W-1:0]          load_index,
	input  logic [7:0]                          load_value,
	input  logic signed [ths_pkg::POS_W-1:0]    pos_x,
	input  logic signed [ths_pkg::POS_W-1:0]    pos_z,
	input  logic                                reverse_quad,
	input  logic                                cfg_we,
	input  logic [ths_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ths_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                done,
	output logic [ths_pkg::HGT_W-1:0]           height,
	output logic                                outside
);
	import ths_pkg::*;

	logic [DIM_W-1:0] width_q, length_q, eff_w, eff_l;
	logic [RECIP_W-1:0] rx_q, rz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(256);
			length_q <= DIM_W'(256);
			rx_q <= RECIP_W'(65536);
			rz_q <= RECIP_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAP_WIDTH: width_q <= cfg_data[DIM_W-1:0];
				REG_MAP_LENGTH: length_q <= cfg_data[DIM_W-1:0];
				REG_RECIP_X: rx_q <= cfg_data;
				REG_RECIP_Z: rz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_w = (width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_q;
	assign eff_l = (length_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : length_q;
	assign busy = 1'b0;

	logic acc;
	assign acc = start && !busy;

	// loads delayed to keep order with queries ahead in the pipe
	logic ld_v_s1, ld_v_s2, ld_v_s3, ld_v_s4;
	logic [ADDR_W-1:0] ld_a_s1, ld_a_s2, ld_a_s3, ld_a_s4;
	logic [7:0] ld_d_s1, ld_d_s2, ld_d_s3, ld_d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1 <= 1'b0;
			ld_v_s2 <= 1'b0;
			ld_v_s3 <= 1'b0;
			ld_v_s4 <= 1'b0;
		end else begin
			ld_v_s1 <= acc && (kind == KIND_LOAD)
				&& ({1'b0, load_index} < 17'(MAX_DIM * MAX_DIM));
			ld_v_s2 <= ld_v_s1;
			ld_v_s3 <= ld_v_s2;
			ld_v_s4 <= ld_v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ld_a_s1 <= load_index;
		ld_d_s1 <= load_value;
		ld_a_s2 <= ld_a_s1;
		ld_d_s2 <= ld_d_s1;
		ld_a_s3 <= ld_a_s2;
		ld_d_s3 <= ld_d_s2;
		ld_a_s4 <= ld_a_s3;
		ld_d_s4 <= ld_d_s3;
	end

	logic fv, qv, pop;
	ths_item_t fitem, qhead;

	ths_front u_front (
		.clk(clk), .arst_n(arst_n), .start(acc), .kind(kind),
		.pos_x(pos_x), .pos_z(pos_z), .reverse_quad(reverse_quad),
		.eff_w(eff_w), .eff_l(eff_l), .recip_x(rx_q), .recip_z(rz_q),
		.item_valid(fv), .item(fitem)
	);

	ths_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(fv), .push_item(fitem),
		.pop(pop), .not_empty(qv), .head(qhead)
	);

	ths_back u_back (
		.clk(clk), .arst_n(arst_n),
		.wr_en(ld_v_s4), .wr_addr(ld_a_s4), .wr_data(ld_d_s4),
		.item_valid(qv), .item(qhead), .pop(pop),
		.done(done), .height(height), .outside(outside)
	);

	`include "terrain_height_sampler_assert.svh"
	`THS_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy)
	`THS_ASSERT_NXT(a_load_no_result, clk, arst_n, ld_v_s4, 1'b1)
	`THS_ASSERT_IMP(a_eff_w_range, clk, arst_n, 1'b1, eff_w <= DIM_W'(MAX_DIM))
	`THS_ASSERT_IMP(a_eff_l_range, clk, arst_n, 1'b1, eff_l <= DIM_W'(MAX_DIM))
endmodule
